[src/lnig_pkg.sv]
// ============================================================================
// lnig_pkg - shared constants for the lattice neighbor index generator
// Field widths, stream port widths and lattice geometry constants.
// ============================================================================
`default_nettype none

package lnig_pkg;

   // item field widths
   localparam int SITE_W = 15;
   localparam int NB_W   = 15;
   localparam int CFG_W  = 7;

   // largest layer count the configuration register can express
   localparam int CFG_MAX = (2 ** CFG_W) - 1;

   // sites per layer are SITE_UNIT * M; SITE_UNIT is a power of two
   localparam int SITE_UNIT = 8;
   localparam int LOG_UNIT  = $clog2(SITE_UNIT);

   localparam int DEF_MAX_LAYERS = 64;

   // stream port widths (fields padded to whole bytes)
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 64;
   localparam int RSP_TUSER_W = 1;
   localparam int CSR_TDATA_W = 8;

endpackage

`default_nettype wire

[src/lattice_neighbor_index_gen_unit.sv]
// ============================================================================
// lattice_neighbor_index_gen_unit - lattice neighbor index generator
// Returns the four neighbor slots of a site of the five-row-periodic lattice.
// ============================================================================
// Takes one site index per transfer and returns its four neighbor slots on a
// lattice of 5M rows and 8*M*M sites, M being the layer count written on the
// csr channel (0 acts as 1, values above MAX_LAYERS act as MAX_LAYERS). A slot
// equal to the site itself is a cut bond (top row, bottom row, ends of the
// middle row). Sites at or beyond 8*M*M come back with index_valid low and all
// slots zero. The unit accepts one site every cycle unless rsp back-pressure
// has filled the pipe. The layer divider resolves one quotient bit per stage.
// Every stage stalls on its own, so bubbles are squeezed out and a held result
// does not block input while the pipe has room. Write csr only while no
// transfer is in flight.
`default_nettype none

module lattice_neighbor_index_gen_unit
   import lnig_pkg::*;
#(
   parameter int MAX_LAYERS = DEF_MAX_LAYERS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // csr: [6:0] layer_count, [7] pad
   input  wire logic                   csr_tvalid,
   output logic                        csr_tready,
   input  wire logic [CSR_TDATA_W-1:0] csr_tdata,
   // req: [14:0] site_index, [15] pad
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // rsp: [14:0] neighbor_a, [29:15] neighbor_b, [44:30] neighbor_c,
   //      [59:45] neighbor_d, [63:60] pad
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   // rsp_tuser: [0] index_valid
   output logic [RSP_TUSER_W-1:0]      rsp_tuser
);

   // effective layer count range and derived widths
   localparam int EFF_MAX = (MAX_LAYERS < CFG_MAX) ? MAX_LAYERS : CFG_MAX;
   localparam int M_W     = $clog2(EFF_MAX + 1);
   localparam int TOT_W   = $clog2(SITE_UNIT * EFF_MAX * EFF_MAX + 1);
   localparam int CW      = M_W + LOG_UNIT;
   localparam int DLW     = M_W + 4;

   // ---------------------------------------------------------------------
   // Configuration: clamp M and precompute the site count at write time, so
   // an item entering right after the write already sees both.
   // ---------------------------------------------------------------------
   logic [CFG_W-1:0]   csr_val;
   logic [M_W-1:0]     m_ff, m_in;
   logic [TOT_W-1:0]   total_ff, total_in;
   logic [2*M_W-1:0]   m_sq;

   assign csr_tready = 1'b1;
   assign csr_val    = csr_tdata[CFG_W-1:0];

   always_comb begin
      priority if (csr_val == '0) begin
         m_in = M_W'(1);
      end else if (csr_val > CFG_W'(EFF_MAX)) begin
         m_in = M_W'(EFF_MAX);
      end else begin
         m_in = M_W'(csr_val);
      end
      m_sq     = (2*M_W)'(m_in) * (2*M_W)'(m_in);
      total_in = TOT_W'({m_sq, {LOG_UNIT{1'b0}}});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_ff     <= M_W'(1);
         total_ff <= TOT_W'(SITE_UNIT);
      end else if (csr_tvalid && csr_tready) begin
         m_ff     <= m_in;
         total_ff <= total_in;
      end
   end

   // ---------------------------------------------------------------------
   // Layer divider: site -> (layer, column in layer), range flag
   // ---------------------------------------------------------------------
   logic                div_valid, div_ready, div_inr;
   logic [SITE_W-1:0]   div_site;
   logic [M_W-1:0]      div_q;
   logic [CW-1:0]       div_col;

   lnig_div #(
      .M_W   (M_W),
      .TOT_W (TOT_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .m         (m_ff),
      .total     (total_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_site   (req_tdata[SITE_W-1:0]),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_site  (div_site),
      .out_q     (div_q),
      .out_col   (div_col),
      .out_inr   (div_inr)
   );

   // ---------------------------------------------------------------------
   // Row decode and neighbor offsets (two stages)
   // ---------------------------------------------------------------------
   logic                  dec_valid, dec_ready, dec_inr;
   logic [SITE_W-1:0]     dec_site;
   logic [3:0][DLW-1:0]   dec_delta;

   lnig_dec #(
      .M_W (M_W)
   ) u_dec (
      .clock     (clock),
      .reset     (reset),
      .m         (m_ff),
      .in_valid  (div_valid),
      .in_ready  (div_ready),
      .in_site   (div_site),
      .in_q      (div_q),
      .in_col    (div_col),
      .in_inr    (div_inr),
      .out_valid (dec_valid),
      .out_ready (dec_ready),
      .out_site  (dec_site),
      .out_delta (dec_delta),
      .out_inr   (dec_inr)
   );

   // ---------------------------------------------------------------------
   // Wrap modulo site count, output register
   // ---------------------------------------------------------------------
   logic [3:0][NB_W-1:0]  nb;
   logic                  idx_valid;

   lnig_wrap #(
      .M_W   (M_W),
      .TOT_W (TOT_W)
   ) u_wrap (
      .clock     (clock),
      .reset     (reset),
      .total     (total_ff),
      .in_valid  (dec_valid),
      .in_ready  (dec_ready),
      .in_site   (dec_site),
      .in_delta  (dec_delta),
      .in_inr    (dec_inr),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_nb    (nb),
      .out_inr   (idx_valid)
   );

   assign rsp_tdata = {(RSP_TDATA_W - 4*NB_W)'(0), nb[3], nb[2], nb[1], nb[0]};
   assign rsp_tuser = RSP_TUSER_W'(idx_valid);

endmodule

`default_nettype wire

[src/lnig_div.sv]
// ============================================================================
// lnig_div - pipelined layer divider
// Splits a site index into layer (quotient) and in-layer column (remainder)
// by the layer size 8*M, one quotient bit per stage; flags in-range sites.
// ============================================================================
`default_nettype none

module lnig_div
   import lnig_pkg::*;
#(
   parameter int M_W   = 7,
   parameter int TOT_W = 17
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [M_W-1:0]        m,
   input  wire logic [TOT_W-1:0]      total,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire logic [SITE_W-1:0]     in_site,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output logic [SITE_W-1:0]          out_site,
   output logic [M_W-1:0]             out_q,
   output logic [M_W+LOG_UNIT-1:0]    out_col,
   output logic                       out_inr
);

   localparam int NS    = M_W + 1;
   localparam int CW    = M_W + LOG_UNIT;
   localparam int PW    = 2 * M_W + LOG_UNIT;
   localparam int CMPW  = ((SITE_W > PW) ? SITE_W : PW) + 1;

   logic                v_ff    [NS];
   logic                rdy     [NS+1];
   logic [SITE_W-1:0]   site_ff [NS];
   logic [SITE_W-1:0]   rem_ff  [NS];
   logic [M_W-1:0]      q_ff    [NS];
   logic                inr_ff  [NS];

   logic [CMPW-1:0]     dv      [1:M_W];
   logic                ge      [1:M_W];
   logic [SITE_W-1:0]   rem_in  [1:M_W];
   logic [M_W-1:0]      q_in    [1:M_W];

   // per-stage ready: a stage moves when empty or when its successor moves
   always_comb begin
      rdy[NS] = out_ready;
      for (int i = NS - 1; i >= 0; i--) begin
         rdy[i] = !v_ff[i] || rdy[i+1];
      end
   end

   assign in_ready = rdy[0];

   // restoring step: stage s decides quotient bit M_W-s
   always_comb begin
      for (int s = 1; s <= M_W; s++) begin
         dv[s]     = CMPW'(m) << (LOG_UNIT + M_W - s);
         ge[s]     = CMPW'(rem_ff[s-1]) >= dv[s];
         rem_in[s] = ge[s] ? SITE_W'(CMPW'(rem_ff[s-1]) - dv[s]) : rem_ff[s-1];
         q_in[s]   = q_ff[s-1] | (ge[s] ? (M_W'(1) << (M_W - s)) : '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NS; i++) begin
            v_ff[i] <= 1'b0;
         end
      end else begin
         if (rdy[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int s = 1; s < NS; s++) begin
            if (rdy[s]) begin
               v_ff[s] <= v_ff[s-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0] && in_valid) begin
         site_ff[0] <= in_site;
         rem_ff[0]  <= in_site;
         q_ff[0]    <= '0;
         inr_ff[0]  <= CMPW'(in_site) < CMPW'(total);
      end
      for (int s = 1; s < NS; s++) begin
         if (rdy[s] && v_ff[s-1]) begin
            site_ff[s] <= site_ff[s-1];
            rem_ff[s]  <= rem_in[s];
            q_ff[s]    <= q_in[s];
            inr_ff[s]  <= inr_ff[s-1];
         end
      end
   end

   assign out_valid = v_ff[NS-1];
   assign out_site  = site_ff[NS-1];
   assign out_q     = q_ff[NS-1];
   assign out_col   = rem_ff[NS-1][CW-1:0];
   assign out_inr   = inr_ff[NS-1];

endmodule

`default_nettype wire

[src/lnig_dec.sv]
// ============================================================================
// lnig_dec - row decode and neighbor offset select
// Stage A finds the row type and in-row column; stage B picks the four
// signed offsets from the row type's neighbor rules (zero = cut bond).
// ============================================================================
`default_nettype none

module lnig_dec
   import lnig_pkg::*;
#(
   parameter int M_W = 7
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic [M_W-1:0]             m,
   input  wire logic                       in_valid,
   output logic                            in_ready,
   input  wire logic [SITE_W-1:0]          in_site,
   input  wire logic [M_W-1:0]             in_q,
   input  wire logic [M_W+LOG_UNIT-1:0]    in_col,
   input  wire logic                       in_inr,
   output logic                            out_valid,
   input  wire logic                       out_ready,
   output logic [SITE_W-1:0]               out_site,
   output logic [3:0][M_W+3:0]             out_delta,
   output logic                            out_inr
);

   localparam int CW  = M_W + LOG_UNIT;
   localparam int DLW = M_W + 4;

   typedef enum logic [2:0] {
      ROW_TOP,
      ROW_UPPER,
      ROW_MID,
      ROW_LOWER,
      ROW_BOT
   } row_type_type;

   typedef struct packed {
      row_type_type  row;
      logic [M_W:0]  c;
      logic          first;
      logic          last;
   } row_info_type;

   logic               a_v_ff, b_v_ff;
   logic               rdy_a, rdy_b;
   logic [SITE_W-1:0]  a_site_ff, b_site_ff;
   logic               a_inr_ff, b_inr_ff;
   row_info_type       a_info_ff, a_info_in;
   logic [3:0][DLW-1:0] b_dlt_ff, b_dlt_in;

   logic [CW-1:0]      m1, m3, m5, m7, base;
   logic [DLW-1:0]     mv, cv, hv, one, t_up, t_lo;
   logic [M_W:0]       c_end;

   assign rdy_b    = !b_v_ff || out_ready;
   assign rdy_a    = !a_v_ff || rdy_b;
   assign in_ready = rdy_a;

   // stage A: row bands at column m, 3m, 5m, 7m
   always_comb begin
      m1 = CW'(m);
      m3 = m1 + (m1 << 1);
      m5 = m1 + (m1 << 2);
      m7 = (m1 << 3) - m1;
      priority if (in_col < m1) begin
         a_info_in.row = ROW_TOP;
         base          = '0;
      end else if (in_col < m3) begin
         a_info_in.row = ROW_UPPER;
         base          = m1;
      end else if (in_col < m5) begin
         a_info_in.row = ROW_MID;
         base          = m3;
      end else if (in_col < m7) begin
         a_info_in.row = ROW_LOWER;
         base          = m5;
      end else begin
         a_info_in.row = ROW_BOT;
         base          = m7;
      end
      a_info_in.c     = (M_W+1)'(in_col - base);
      a_info_in.first = (in_q == '0) && (a_info_in.row == ROW_TOP);
      a_info_in.last  = (in_q == m - M_W'(1)) && (a_info_in.row == ROW_BOT);
   end

   // stage B: offsets; two's complement, sign handled at the wrap stage
   always_comb begin
      mv    = DLW'(m);
      cv    = DLW'(a_info_ff.c);
      hv    = DLW'(a_info_ff.c >> 1);
      one   = DLW'(1);
      t_up  = hv - cv - mv;
      t_lo  = hv - cv + (mv << 1);
      c_end = (M_W+1)'({m, 1'b0}) - (M_W+1)'(1);
      b_dlt_in = '0;
      unique case (a_info_ff.row)
         ROW_TOP: begin
            b_dlt_in[0] = one + mv + cv;
            b_dlt_in[1] = mv + cv;
            b_dlt_in[2] = a_info_ff.first ? '0 : -mv;
         end
         ROW_UPPER: begin
            if (a_info_ff.c[0]) begin
               b_dlt_in[0] = mv << 1;
               b_dlt_in[1] = mv << 2;
               b_dlt_in[2] = -one;
            end else begin
               b_dlt_in[0] = one;
               b_dlt_in[1] = mv << 2;
               b_dlt_in[2] = mv << 1;
            end
            b_dlt_in[3] = t_up;
         end
         ROW_MID: begin
            if (a_info_ff.c[0]) begin
               b_dlt_in[0] = (a_info_ff.c == c_end) ? '0 : one;
               b_dlt_in[1] = mv << 1;
            end else begin
               b_dlt_in[0] = mv << 1;
               b_dlt_in[1] = (a_info_ff.c == '0) ? '0 : -one;
            end
            b_dlt_in[2] = -(mv << 1);
         end
         ROW_LOWER: begin
            if (a_info_ff.c[0]) begin
               b_dlt_in[0] = t_lo;
               b_dlt_in[1] = -one;
               b_dlt_in[2] = -(mv << 2);
               b_dlt_in[3] = -(mv << 1);
            end else begin
               b_dlt_in[0] = one;
               b_dlt_in[1] = t_lo;
               b_dlt_in[2] = -(mv << 1);
               b_dlt_in[3] = -(mv << 2);
            end
         end
         ROW_BOT: begin
            b_dlt_in[0] = a_info_ff.last ? '0 : mv;
            b_dlt_in[1] = cv - (mv << 1);
            b_dlt_in[2] = cv - (mv << 1) + one;
         end
         default: begin
            b_dlt_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
      end else begin
         if (rdy_a) begin
            a_v_ff <= in_valid;
         end
         if (rdy_b) begin
            b_v_ff <= a_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_a && in_valid) begin
         a_site_ff <= in_site;
         a_inr_ff  <= in_inr;
         a_info_ff <= a_info_in;
      end
      if (rdy_b && a_v_ff) begin
         b_site_ff <= a_site_ff;
         b_inr_ff  <= a_inr_ff;
         b_dlt_ff  <= b_dlt_in;
      end
   end

   assign out_valid = b_v_ff;
   assign out_site  = b_site_ff;
   assign out_delta = b_dlt_ff;
   assign out_inr   = b_inr_ff;

endmodule

`default_nettype wire

[src/lnig_wrap.sv]
// ============================================================================
// lnig_wrap - modular wrap and output register
// Adds each offset to the site, folds the sum into [0, total) and holds the
// result for the downstream transfer; out-of-range sites give zeros.
// ============================================================================
`default_nettype none

module lnig_wrap
   import lnig_pkg::*;
#(
   parameter int M_W   = 7,
   parameter int TOT_W = 17
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [TOT_W-1:0]      total,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire logic [SITE_W-1:0]     in_site,
   input  wire logic [3:0][M_W+3:0]   in_delta,
   input  wire logic                  in_inr,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output logic [3:0][NB_W-1:0]       out_nb,
   output logic                       out_inr
);

   localparam int AW = ((SITE_W > TOT_W) ? SITE_W : TOT_W) + 2;

   logic                  v_ff, rdy;
   logic [3:0][NB_W-1:0]  nb_ff, nb_in;
   logic                  inr_ff;
   logic [AW-1:0]         sum [4];
   logic [AW-1:0]         s_p [4];
   logic [AW-1:0]         s_m [4];
   logic [AW-1:0]         res [4];
   logic [AW-1:0]         tot_x;

   assign rdy      = !v_ff || out_ready;
   assign in_ready = rdy;
   assign tot_x    = AW'(total);

   // |offset| < total, so one fold either way is enough
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         sum[k] = AW'(in_site) + AW'($signed(in_delta[k]));
         s_p[k] = sum[k] + tot_x;
         s_m[k] = sum[k] - tot_x;
         if (sum[k][AW-1]) begin
            res[k] = s_p[k];
         end else if (s_m[k][AW-1]) begin
            res[k] = sum[k];
         end else begin
            res[k] = s_m[k];
         end
         nb_in[k] = in_inr ? res[k][NB_W-1:0] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (rdy) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy && in_valid) begin
         nb_ff  <= nb_in;
         inr_ff <= in_inr;
      end
   end

   assign out_valid = v_ff;
   assign out_nb    = nb_ff;
   assign out_inr   = inr_ff;

endmodule

`default_nettype wire

[src/lnig_checker.sv]
// ============================================================================
// lnig_checker - port-level checks for the neighbor index generator
// Watches the top level's stream ports; attached by bind.
// ============================================================================
`default_nettype none

module lnig_checker
   import lnig_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   csr_tvalid,
   input wire logic                   csr_tready,
   input wire logic [CSR_TDATA_W-1:0] csr_tdata,
   input wire logic                   req_tvalid,
   input wire logic                   req_tready,
   input wire logic [REQ_TDATA_W-1:0] req_tdata,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [RSP_TDATA_W-1:0] rsp_tdata,
   input wire logic [RSP_TUSER_W-1:0] rsp_tuser
);

   // a stalled result holds until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp changed while stalled");

   // reset empties the pipe
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid set right after reset");

   // a consumer that always takes results never throttles the request side
   a_no_backpressure: assert property (@(posedge clock)
      rsp_tready |-> req_tready)
      else $error("req_tready low while rsp_tready high");

   // out-of-range sites report all-zero slots
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("nonzero slots on an out-of-range site");

endmodule

bind lattice_neighbor_index_gen_unit lnig_checker u_lnig_checker (.*);

`default_nettype wire

[verif/tb_lattice_neighbor_index_gen_unit.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_lattice_neighbor_index_gen_unit - neighbor index generator testbench
// Streams site indices through the unit under several layer counts and traffic
// patterns. Every result is checked against a hand-typed answer or an in-bench neighbor predictor.
// ============================================================================

module tb_lattice_neighbor_index_gen_unit;
   import lnig_pkg::*;

   // row position inside one five-row layer
   localparam int ROWS_PER_LAYER  = 5;
   localparam int ROW_SINGLE_LOW  = 0;   // M sites, up bond cut on the very top row
   localparam int ROW_PAIR_LOW    = 1;   // 2M sites
   localparam int ROW_MIDDLE      = 2;   // 2M sites, sideways bonds cut at row ends
   localparam int ROW_PAIR_HIGH   = 3;   // 2M sites
   localparam int ROW_SINGLE_HIGH = 4;   // M sites, down bond cut on the very bottom row

   localparam int RANDOM_PHASES   = 8;
   localparam int ITEMS_PER_PHASE = 225;
   localparam int SETTLE_CYCLES   = 20;    // longer than a result takes to cross the pipe
   localparam int WATCHDOG_LIMIT  = 2000;  // cycles with no transfer anywhere
   localparam int IDLE_PCT        = 87;
   localparam int BOTH_IDLE_PCT   = 11;

   typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

   typedef struct packed {
      logic            index_valid;
      logic [NB_W-1:0] nb_a;
      logic [NB_W-1:0] nb_b;
      logic [NB_W-1:0] nb_c;
      logic [NB_W-1:0] nb_d;
   } nb_result_t;

   typedef struct {
      logic [CFG_W-1:0]  layers;
      logic [SITE_W-1:0] site;
      bit                typed;    // want holds a hand-derived answer
      nb_result_t        want;
   } dir_row_t;

   localparam nb_result_t NO_WANT      = '0;
   localparam nb_result_t INVALID_SITE = '0;  // out of range: all slots zero, flag low

   // --------------------------------------------------------------------------
   // DUT hookup; every input has a known value from time zero
   // --------------------------------------------------------------------------
   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   csr_tvalid = 1'b0;
   logic                   csr_tready;
   logic [CSR_TDATA_W-1:0] csr_tdata  = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b1;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;

   lattice_neighbor_index_gen_unit dut (
      .clock      (clock),
      .reset      (reset),
      .csr_tvalid (csr_tvalid),
      .csr_tready (csr_tready),
      .csr_tdata  (csr_tdata),    // [6:0] layer_count, [7] pad
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [14:0] site_index, [15] pad
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // [14:0] a, [29:15] b, [44:30] c, [59:45] d, [63:60] pad
      .rsp_tuser  (rsp_tuser)     // [0] index_valid
   );

   // 8 ns period
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // --------------------------------------------------------------------------
   // Predictor state: our copy of the layer count register plus the queue of
   // neighbor sets still owed by the unit, oldest first.
   // --------------------------------------------------------------------------
   logic [CFG_W-1:0] layer_reg = 7'd1;
   nb_result_t       neighbor_expect_q[$];
   int               mismatch_count = 0;
   int               quiet_cycles   = 0;
   int               send_gap_pct   = 0;
   int               recv_stall_pct = 0;

   // register value -> layer count actually used (0 acts as 1, clamp at max)
   function automatic int effective_layers(input logic [CFG_W-1:0] layers);
      int m;
      m = layers;
      if (m < 1) m = 1;
      if (m > DEF_MAX_LAYERS) m = DEF_MAX_LAYERS;
      return m;
   endfunction

   function automatic int wrap_site(input int site, input int delta, input int total);
      int v;
      v = (site + delta) % total;
      if (v < 0) v += total;
      return v;
   endfunction

   // neighbor slots of one site; a slot equal to the site is a cut bond
   function automatic nb_result_t lattice_neighbors(input logic [CFG_W-1:0] layers,
                                                    input logic [SITE_W-1:0] site);
      int         m, total, layer_size, s, col, row;
      int         nb[4];
      nb_result_t r;
      m          = effective_layers(layers);
      layer_size = SITE_UNIT * m;
      total      = layer_size * m;
      s          = site;
      r          = '0;
      if (s >= total) return r;

      // locate row and column: rows of M, 2M, 2M, 2M, M within each layer
      col = s % layer_size;
      row = ROWS_PER_LAYER * (s / layer_size);
      if (col >= m) begin
         row++; col -= m;
         if (col >= 2 * m) begin
            row++; col -= 2 * m;
            if (col >= 2 * m) begin
               row++; col -= 2 * m;
               if (col >= 2 * m) begin
                  row++; col -= 2 * m;
               end
            end
         end
      end

      case (row % ROWS_PER_LAYER)
         ROW_SINGLE_LOW: begin
            nb[0] = wrap_site(s, 1 + m + col, total);
            nb[1] = wrap_site(s, m + col, total);
            nb[2] = (row == 0) ? s : wrap_site(s, -m, total);
            nb[3] = s;
         end
         ROW_PAIR_LOW: begin
            if (col % 2 == 1) begin
               nb[0] = wrap_site(s, 2 * m, total);
               nb[1] = wrap_site(s, 4 * m, total);
               nb[2] = wrap_site(s, -1, total);
               nb[3] = wrap_site(s, -col - m + (col - 1) / 2, total);
            end else begin
               nb[0] = wrap_site(s, 1, total);
               nb[1] = wrap_site(s, 4 * m, total);
               nb[2] = wrap_site(s, 2 * m, total);
               nb[3] = wrap_site(s, -col - m + col / 2, total);
            end
         end
         ROW_MIDDLE: begin
            if (col % 2 == 1) begin
               nb[0] = (col == 2 * m - 1) ? s : wrap_site(s, 1, total);
               nb[1] = wrap_site(s, 2 * m, total);
            end else begin
               nb[0] = wrap_site(s, 2 * m, total);
               nb[1] = (col == 0) ? s : wrap_site(s, -1, total);
            end
            nb[2] = wrap_site(s, -2 * m, total);
            nb[3] = s;
         end
         ROW_PAIR_HIGH: begin
            if (col % 2 == 1) begin
               nb[0] = wrap_site(s, -col + 2 * m + (col - 1) / 2, total);
               nb[1] = wrap_site(s, -1, total);
               nb[2] = wrap_site(s, -4 * m, total);
               nb[3] = wrap_site(s, -2 * m, total);
            end else begin
               nb[0] = wrap_site(s, 1, total);
               nb[1] = wrap_site(s, -col + 2 * m + col / 2, total);
               nb[2] = wrap_site(s, -2 * m, total);
               nb[3] = wrap_site(s, -4 * m, total);
            end
         end
         default: begin  // ROW_SINGLE_HIGH
            nb[0] = (row == ROWS_PER_LAYER * m - 1) ? s : wrap_site(s, m, total);
            nb[1] = wrap_site(s, col - 2 * m, total);
            nb[2] = wrap_site(s, col - 2 * m + 1, total);
            nb[3] = s;
         end
      endcase

      r.index_valid = 1'b1;
      r.nb_a        = NB_W'(nb[0]);
      r.nb_b        = NB_W'(nb[1]);
      r.nb_c        = NB_W'(nb[2]);
      r.nb_d        = NB_W'(nb[3]);
      return r;
   endfunction

   // --------------------------------------------------------------------------
   // Stimulus helpers. Inputs move on the falling edge, handshakes are
   // sampled on the rising edge.
   // --------------------------------------------------------------------------

   // one site transfer, with optional idle cycles in front of it
   task automatic send_site(input logic [SITE_W-1:0] site, input bit typed,
                            input nb_result_t typed_want);
      @(negedge clock);
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {{(REQ_TDATA_W - SITE_W){1'b0}}, site};
      do @(posedge clock); while (!req_tready);
      neighbor_expect_q.push_back(typed ? typed_want : lattice_neighbors(layer_reg, site));
   endtask

   // stop sending and wait for every owed result; the unit is idle after that
   task automatic wait_until_drained;
      @(negedge clock);
      req_tvalid = 1'b0;
      while (neighbor_expect_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_layer_count(input logic [CFG_W-1:0] value);
      @(negedge clock);
      csr_tvalid = 1'b1;
      csr_tdata  = {{(CSR_TDATA_W - CFG_W){1'b0}}, value};
      do @(posedge clock); while (!csr_tready);
      layer_reg = value;
      @(negedge clock);
      csr_tvalid = 1'b0;
   endtask

   // mix of in-range sites, row-boundary sites and raw 15-bit values
   function automatic logic [SITE_W-1:0] pick_site;
      int m, layer, sel;
      int offs[10];
      m   = effective_layers(layer_reg);
      sel = $urandom_range(99);
      if (sel < 60) return SITE_W'($urandom_range(SITE_UNIT * m * m - 1));
      if (sel < 85) begin
         // first and last site of each row in a random layer
         offs  = '{0, m - 1, m, 3 * m - 1, 3 * m, 5 * m - 1, 5 * m, 7 * m - 1, 7 * m,
                   8 * m - 1};
         layer = $urandom_range(m - 1);
         return SITE_W'(layer * SITE_UNIT * m + offs[$urandom_range(9)]);
      end
      return SITE_W'($urandom_range((1 << SITE_W) - 1));
   endfunction

   // --------------------------------------------------------------------------
   // Directed rows. Hand-typed answers only where they are obvious: lattice
   // corners at M=1 and M=64, and sites past the end of the lattice.
   // --------------------------------------------------------------------------
   dir_row_t directed_rows[24] = '{
      // reset layer count (M=1, 8 sites): walk every site, then out of range
      '{7'd1,   15'd0,     1'b1, '{1'b1, 15'd2, 15'd1, 15'd0, 15'd0}},
      '{7'd1,   15'd1,     1'b0, NO_WANT},
      '{7'd1,   15'd2,     1'b0, NO_WANT},
      '{7'd1,   15'd3,     1'b0, NO_WANT},
      '{7'd1,   15'd4,     1'b0, NO_WANT},
      '{7'd1,   15'd5,     1'b0, NO_WANT},
      '{7'd1,   15'd6,     1'b0, NO_WANT},
      '{7'd1,   15'd7,     1'b1, '{1'b1, 15'd7, 15'd5, 15'd6, 15'd7}},
      '{7'd1,   15'd8,     1'b1, INVALID_SITE},
      '{7'd1,   15'd32767, 1'b1, INVALID_SITE},
      // largest lattice: fills all 15 bits, ends of the first three rows and of the last row
      '{7'd64,  15'd0,     1'b1, '{1'b1, 15'd65, 15'd64, 15'd0, 15'd0}},
      '{7'd64,  15'd63,    1'b0, NO_WANT},
      '{7'd64,  15'd64,    1'b0, NO_WANT},
      '{7'd64,  15'd191,   1'b0, NO_WANT},
      '{7'd64,  15'd192,   1'b0, NO_WANT},
      '{7'd64,  15'd319,   1'b0, NO_WANT},
      '{7'd64,  15'd32704, 1'b0, NO_WANT},
      '{7'd64,  15'd32767, 1'b0, NO_WANT},
      // zero layer count behaves as one
      '{7'd0,   15'd7,     1'b1, '{1'b1, 15'd7, 15'd5, 15'd6, 15'd7}},
      '{7'd0,   15'd8,     1'b1, INVALID_SITE},
      // register maximum clamps to 64 layers
      '{7'd127, 15'd0,     1'b1, '{1'b1, 15'd65, 15'd64, 15'd0, 15'd0}},
      '{7'd127, 15'd32767, 1'b0, NO_WANT},
      // M=2: last site and first one past the end
      '{7'd2,   15'd31,    1'b0, NO_WANT},
      '{7'd2,   15'd32,    1'b1, INVALID_SITE}
   };

   // --------------------------------------------------------------------------
   // Main sequence
   // --------------------------------------------------------------------------
   initial begin : main_seq
      logic [CFG_W-1:0] phase_layers[RANDOM_PHASES];
      idle_mode_e       mode;
      int               p;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed part, full-rate traffic; rewrite the register only when a
      // row asks for a different layer count
      foreach (directed_rows[i]) begin
         if (directed_rows[i].layers != layer_reg) begin
            wait_until_drained();
            write_layer_count(directed_rows[i].layers);
         end
         send_site(directed_rows[i].site, directed_rows[i].typed, directed_rows[i].want);
      end

      // random part: each phase gets its own layer count and traffic pattern
      phase_layers = '{7'd64, 7'd3, 7'd127, 7'd0, 7'd1, 7'd2,
                       CFG_W'($urandom_range(DEF_MAX_LAYERS, 1)),
                       CFG_W'($urandom_range(CFG_MAX))};
      for (p = 0; p < RANDOM_PHASES; p++) begin
         wait_until_drained();
         write_layer_count(phase_layers[p]);
         mode = idle_mode_e'(p % 4);
         case (mode)
            IDLE_NONE: begin send_gap_pct = 0;             recv_stall_pct = 0;             end
            IDLE_SEND: begin send_gap_pct = IDLE_PCT;      recv_stall_pct = 0;             end
            IDLE_RECV: begin send_gap_pct = 0;             recv_stall_pct = IDLE_PCT;      end
            default:   begin send_gap_pct = BOTH_IDLE_PCT; recv_stall_pct = BOTH_IDLE_PCT; end
         endcase
         repeat (ITEMS_PER_PHASE) send_site(pick_site(), 1'b0, NO_WANT);
      end

      send_gap_pct   = 0;
      recv_stall_pct = 0;
      wait_until_drained();
      // idle for SETTLE_CYCLES so that any stray extra result shows up
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && neighbor_expect_q.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // receiver backpressure
   always @(negedge clock) begin
      rsp_tready = ($urandom_range(99) >= recv_stall_pct);
   end

   // --------------------------------------------------------------------------
   // Result checker: every rsp transfer against the oldest expectation
   // --------------------------------------------------------------------------
   task automatic check_field(input string name, input logic [NB_W-1:0] want,
                              input logic [NB_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   nb_result_t rsp_got, rsp_want;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_got.index_valid = rsp_tuser[0];
         rsp_got.nb_a        = rsp_tdata[NB_W-1:0];
         rsp_got.nb_b        = rsp_tdata[2*NB_W-1:NB_W];
         rsp_got.nb_c        = rsp_tdata[3*NB_W-1:2*NB_W];
         rsp_got.nb_d        = rsp_tdata[4*NB_W-1:3*NB_W];
         if (neighbor_expect_q.size() == 0) begin
            $display("%0t: result with none expected, expected nothing, actual %h",
                     $time, rsp_got);
            mismatch_count++;
         end else begin
            rsp_want = neighbor_expect_q.pop_front();
            check_field("index_valid", NB_W'(rsp_want.index_valid), NB_W'(rsp_got.index_valid));
            check_field("neighbor_a", rsp_want.nb_a, rsp_got.nb_a);
            check_field("neighbor_b", rsp_want.nb_b, rsp_got.nb_b);
            check_field("neighbor_c", rsp_want.nb_c, rsp_got.nb_c);
            check_field("neighbor_d", rsp_want.nb_d, rsp_got.nb_d);
         end
      end
   end

   // watchdog: too long without a transfer on any channel means a hang
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_tvalid && csr_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

endmodule
